>>> rtl/pidl_pkg.sv
`default_nettype none
package pidl_pkg;

  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_RD_READ,
    DP_INS_RD,
    DP_INS_WR,
    DP_INS_VAL,
    DP_DEL_RD,
    DP_DEL_WR,
    DP_DEL_DONE
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_READ_OUT,
    S_INS_LOOP,
    S_INS_WR,
    S_INS_VAL,
    S_DEL_LOOP,
    S_DEL_WR,
    S_FIN
  } ctl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic       finish;
    logic [1:0] fin_status;
    logic       fin_use_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       bad;
    logic       full;
    logic       ins_last;
    logic       del_last;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/pidl_ctrl.sv
`default_nettype none
module pidl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire pidl_pkg::dp_stat_t stat,
  output pidl_pkg::dp_cmd_t       cmd
);
  import pidl_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.op         = DP_NOP;
    cmd.finish     = 1'b0;
    cmd.fin_status = ST_OK;
    cmd.fin_use_rd = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = DP_CAPTURE;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_BAD_POS;
          state_nxt      = S_IDLE;
        end else if (stat.kind == KIND_INSERT && stat.full) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FULL;
          state_nxt      = S_IDLE;
        end else if (stat.kind == KIND_INSERT) begin
          state_nxt = S_INS_LOOP;
        end else if (stat.kind == KIND_DELETE) begin
          state_nxt = S_DEL_LOOP;
        end else begin
          cmd.op    = DP_RD_READ;
          state_nxt = S_READ_OUT;
        end
      end
      S_READ_OUT: begin
        cmd.finish     = 1'b1;
        cmd.fin_use_rd = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_INS_LOOP: begin
        if (stat.ins_last) begin
          state_nxt = S_INS_VAL;
        end else begin
          cmd.op    = DP_INS_RD;
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.op    = DP_INS_WR;
        state_nxt = S_INS_LOOP;
      end
      S_INS_VAL: begin
        cmd.op    = DP_INS_VAL;
        state_nxt = S_FIN;
      end
      S_DEL_LOOP: begin
        if (stat.del_last) begin
          cmd.op    = DP_DEL_DONE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = DP_DEL_RD;
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.op    = DP_DEL_WR;
        state_nxt = S_DEL_LOOP;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/pidl_dp.sv
`default_nettype none
module pidl_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [1:0]                          in_kind,
  input  wire logic [pidl_pkg::POS_W-1:0]          in_position,
  input  wire logic signed [pidl_pkg::DATA_W-1:0]  in_value,
  input  wire pidl_pkg::dp_cmd_t                   cmd,
  output pidl_pkg::dp_stat_t                       stat,
  output logic                                     out_valid,
  output logic [1:0]                               out_status,
  output logic signed [pidl_pkg::DATA_W-1:0]       out_read_value,
  output logic [pidl_pkg::COUNT_W-1:0]             out_count
);
  import pidl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [1:0]        kind_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0] rdata_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [CW-1:0]     out_count_r;

  logic [PW-1:0] pos_ext, count_ext, idx_ext;
  logic [PW-1:0] pos_m1, idx_m1;
  logic [PW-1:0] out_cnt_ext;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign pos_ext   = PW'(pos_r);
  assign count_ext = PW'(count_r);
  assign idx_ext   = PW'(idx_r);
  assign pos_m1    = pos_ext - PW'(1);
  assign idx_m1    = idx_ext - PW'(1);

  always_comb begin
    stat.kind     = kind_r;
    stat.full     = (count_ext == PW'(CAPACITY));
    stat.ins_last = (idx_ext == pos_m1);
    stat.del_last = (idx_r == count_r);
    case (kind_r)
      KIND_INSERT: stat.bad = (pos_r == '0) || (pos_ext > count_ext + PW'(1));
      KIND_DELETE,
      KIND_READ:   stat.bad = (pos_r == '0) || (pos_ext > count_ext);
      default:     stat.bad = 1'b1;
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = pos_m1[AW-1:0];
    wr_addr   = idx_r[AW-1:0];
    wr_data   = rdata_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    case (cmd.op)
      DP_RD_READ: begin
        rd_en = 1'b1;
      end
      DP_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1[AW-1:0];
      end
      DP_INS_WR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r - CW'(1);
      end
      DP_INS_VAL: begin
        wr_en     = 1'b1;
        wr_addr   = pos_m1[AW-1:0];
        wr_data   = val_r;
        count_nxt = count_r + CW'(1);
      end
      DP_DEL_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[AW-1:0];
      end
      DP_DEL_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_m1[AW-1:0];
        idx_nxt = idx_r + CW'(1);
      end
      DP_DEL_DONE: begin
        count_nxt = count_r - CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // request capture; idx starts at the first slot that moves
  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) begin
      kind_r <= in_kind;
      pos_r  <= in_position;
      val_r  <= in_value;
      idx_r  <= (in_kind == KIND_DELETE) ? CW'(in_position) : count_r;
    end else begin
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= cmd.fin_status;
      out_rd_r     <= cmd.fin_use_rd ? rdata_r : '0;
      out_count_r  <= count_r;
    end
  end

  assign out_cnt_ext    = PW'(out_count_r);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rd_r;
  assign out_count      = out_cnt_ext[COUNT_W-1:0];

endmodule
`default_nettype wire

>>> rtl/positional_insert_delete_list.sv
// Ordered list of up to CAPACITY signed 32-bit entries held in a single-port
// array memory. A transaction is taken when start is high and busy is low;
// its result appears on the out_ ports for exactly one cycle with out_valid
// high, and there is no way to hold it off, so sample it then. Every entry
// that shifts costs one memory read plus one write. Busy covers the check
// (a reject ends there), a read's fetch, an insert's shift of p..count up
// plus value write, or a delete's shift of the entries after p down. The
// strobe comes when busy first falls, and a new start is taken in that cycle.
`default_nettype none
module positional_insert_delete_list #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_kind,
  input  wire logic [pidl_pkg::POS_W-1:0]          in_position,
  input  wire logic signed [pidl_pkg::DATA_W-1:0]  in_value,
  output logic                                     out_valid,
  output logic [1:0]                               out_status,
  output logic signed [pidl_pkg::DATA_W-1:0]       out_read_value,
  output logic [pidl_pkg::COUNT_W-1:0]             out_count
);
  import pidl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pidl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  pidl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

endmodule
`default_nettype wire

>>> rtl/pidl_chk.sv
`default_nettype none
module pidl_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               out_valid,
  input wire logic [1:0]                         out_status,
  input wire logic signed [pidl_pkg::DATA_W-1:0] out_read_value
);
  import pidl_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_value == '0)
    else $error("rejected transaction returned nonzero read value");

endmodule

bind positional_insert_delete_list pidl_chk u_pidl_chk (.*);
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pidl_pkg::*;

  localparam int CAPACITY = 64;
  localparam int NUM_RANDOM = 750;
  localparam int QUIET_TAIL = 100;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] rd;
    logic [6:0]         count;
  } list_result_t;

  typedef struct {
    logic [1:0]         kind;
    logic [6:0]         pos;
    logic signed [31:0] value;
    bit                 fixed;
    logic [1:0]         status;
    logic signed [31:0] rd;
    logic [6:0]         count;
  } directed_row_t;

  localparam int NUM_DIRECTED = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = KIND_INSERT;
  logic [6:0] in_position = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [31:0] out_read_value;
  logic [6:0] out_count;

  logic signed [31:0] list_mem [CAPACITY];
  int list_len;
  list_result_t pending_results [$];
  list_result_t oldest;
  int err_count = 0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{KIND_READ,   7'd1,   32'sd0,           1'b1, ST_BAD_POS, 32'sd0,           7'd0},
    '{KIND_DELETE, 7'd1,   32'sd0,           1'b1, ST_BAD_POS, 32'sd0,           7'd0},
    '{KIND_INSERT, 7'd0,   32'sd5,           1'b1, ST_BAD_POS, 32'sd0,           7'd0},
    '{KIND_INSERT, 7'd2,   32'sd5,           1'b1, ST_BAD_POS, 32'sd0,           7'd0},
    '{KIND_UNUSED, 7'd1,   32'sd5,           1'b1, ST_BAD_POS, 32'sd0,           7'd0},
    '{KIND_INSERT, 7'd1,   32'sh8000_0000,   1'b1, ST_OK,      32'sd0,           7'd1},
    '{KIND_INSERT, 7'd2,   32'sh7FFF_FFFF,   1'b1, ST_OK,      32'sd0,           7'd2},
    '{KIND_READ,   7'd1,   32'sd0,           1'b1, ST_OK,      32'sh8000_0000,   7'd2},
    '{KIND_READ,   7'd2,   32'sd0,           1'b1, ST_OK,      32'sh7FFF_FFFF,   7'd2},
    '{KIND_READ,   7'd3,   32'sd0,           1'b1, ST_BAD_POS, 32'sd0,           7'd2},
    '{KIND_INSERT, 7'd127, 32'sd9,           1'b1, ST_BAD_POS, 32'sd0,           7'd2},
    '{KIND_INSERT, 7'd1,   -32'sd1,          1'b1, ST_OK,      32'sd0,           7'd3},
    '{KIND_INSERT, 7'd3,   32'sd0,           1'b1, ST_OK,      32'sd0,           7'd4},
    '{KIND_READ,   7'd3,   32'sd0,           1'b1, ST_OK,      32'sd0,           7'd4},
    '{KIND_DELETE, 7'd0,   32'sd0,           1'b1, ST_BAD_POS, 32'sd0,           7'd4},
    '{KIND_DELETE, 7'd5,   32'sd0,           1'b1, ST_BAD_POS, 32'sd0,           7'd4},
    '{KIND_DELETE, 7'd127, 32'sd0,           1'b1, ST_BAD_POS, 32'sd0,           7'd4},
    '{KIND_DELETE, 7'd2,   32'sd0,           1'b1, ST_OK,      32'sd0,           7'd3},
    '{KIND_READ,   7'd2,   32'sh1234_5678,   1'b0, ST_OK,      32'sd0,           7'd0},
    '{KIND_DELETE, 7'd3,   32'sd0,           1'b0, ST_OK,      32'sd0,           7'd0},
    '{KIND_DELETE, 7'd1,   32'sd0,           1'b0, ST_OK,      32'sd0,           7'd0},
    '{KIND_READ,   7'd1,   32'sd0,           1'b0, ST_OK,      32'sd0,           7'd0},
    '{KIND_INSERT, 7'd2,   32'sh5A5A_5A5A,   1'b0, ST_OK,      32'sd0,           7'd0},
    '{KIND_UNUSED, 7'd127, -32'sd1,          1'b1, ST_BAD_POS, 32'sd0,           7'd2}
  };

  positional_insert_delete_list #(.CAPACITY(CAPACITY)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_position(in_position),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_count(out_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_result_t apply_request(logic [1:0] kind, logic [6:0] pos,
                                                 logic signed [31:0] value);
    list_result_t r;
    int p;
    int i;
    r.status = ST_OK;
    r.rd = '0;
    p = pos;
    case (kind)
      KIND_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = value;
          list_len++;
        end
      end
      KIND_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      KIND_READ: begin
        if (p < 1 || p > list_len) r.status = ST_BAD_POS;
        else r.rd = list_mem[p-1];
      end
      default: r.status = ST_BAD_POS;
    endcase
    r.count = 7'(list_len);
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // one transaction; start stays high until it is taken
  task automatic issue(logic [1:0] kind, logic [6:0] pos, logic signed [31:0] value,
                       bit fixed, list_result_t fixed_res);
    list_result_t r;
    in_kind <= kind;
    in_position <= pos;
    in_value <= value;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    r = apply_request(kind, pos, value);
    if (fixed) pending_results.push_back(fixed_res);
    else pending_results.push_back(r);
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result status=%0d count=%0d",
                                out_status, out_count));
      end else begin
        oldest = pending_results.pop_front();
        if (out_status !== oldest.status)
          note_mismatch($sformatf("status got %0d exp %0d", out_status, oldest.status));
        if (out_read_value !== oldest.rd)
          note_mismatch($sformatf("read_value got %0d exp %0d", out_read_value, oldest.rd));
        if (out_count !== oldest.count)
          note_mismatch($sformatf("count got %0d exp %0d", out_count, oldest.count));
      end
    end
  end

  initial begin
    list_result_t res;
    logic [1:0] k;
    logic [6:0] p;
    logic signed [31:0] v;
    int limit;
    int roll;
    bit filling;
    bit quiet;

    list_len = 0;
    foreach (list_mem[i]) list_mem[i] = '0;
    filling = 1'b1;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 12));
      res.status = directed_rows[i].status;
      res.rd = directed_rows[i].rd;
      res.count = directed_rows[i].count;
      issue(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].value,
            directed_rows[i].fixed, res);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n % 250 == 125) begin
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end else if (!quiet && n < NUM_RANDOM - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        idle_gap($urandom_range(1, 12));
      end

      if (list_len == 0) filling = 1'b1;
      else if (list_len == CAPACITY && $urandom_range(0, 7) == 0) filling = 1'b0;

      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        k = 2'($urandom_range(0, 3));
        p = 7'($urandom_range(0, 127));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 25) k = KIND_READ;
        else if (filling ? roll < 80 : roll < 45) k = KIND_INSERT;
        else k = KIND_DELETE;
        limit = (k == KIND_INSERT) ? list_len + 1 : list_len;
        if (limit == 0) limit = 1;
        roll = $urandom_range(0, 99);
        if (roll < 10) p = 7'd1;
        else if (roll < 20) p = 7'(limit);
        else p = 7'($urandom_range(1, limit));
      end

      roll = $urandom_range(0, 99);
      if (roll < 5) v = 32'sh8000_0000;
      else if (roll < 10) v = 32'sh7FFF_FFFF;
      else v = $urandom;

      issue(k, p, v, 1'b0, res);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
